/* src/smm_pkg.sv */
// Shared types, sizes and the helper function of the small matrix multiplier.
package smm_pkg;

  localparam int MAX_DIM = 8;
  localparam int ELEM_BITS = 16;

  localparam int ELEM_PORT_W = 16;
  localparam int CFG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W = 35;

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int AREA_W = 2 * DIM_W;
  localparam int MUL_W = 2 * ELEM_BITS;
  localparam int EXT_W = (MUL_W > PROD_W) ? MUL_W : PROD_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  typedef enum logic [1:0] {
    CMD_STORE_A,
    CMD_STORE_B,
    CMD_RUN,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                    kind;
    logic [ADDR_W-1:0]            addr;
    logic signed [ELEM_BITS-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] cols_b;
  } dims_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } back_state_t;

  function automatic logic [DIM_W-1:0] dim_eff(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

/* src/smm_front.sv */
// Front end: configuration registers, load counting and item classification.
module smm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [smm_pkg::ELEM_PORT_W-1:0] element,
  input  logic                                q_full,
  output logic                                push,
  output smm_pkg::cmd_t                       push_cmd,
  output smm_pkg::dims_t                      dims
);

  logic [smm_pkg::CFG_W-1:0] rows_a;
  logic [smm_pkg::CFG_W-1:0] cols_a;
  logic [smm_pkg::CFG_W-1:0] rows_b;
  logic [smm_pkg::CFG_W-1:0] cols_b;
  logic [smm_pkg::CNT_W-1:0] load_count;
  logic                      loading_b;

  logic [smm_pkg::DIM_W-1:0]  ra;
  logic [smm_pkg::DIM_W-1:0]  ca;
  logic [smm_pkg::DIM_W-1:0]  rb;
  logic [smm_pkg::DIM_W-1:0]  cb;
  logic [smm_pkg::AREA_W-1:0] area;
  logic [smm_pkg::CNT_W-1:0]  count_inc;
  logic                       done;
  logic                       cfg_wr;

  assign ra = smm_pkg::dim_eff(rows_a);
  assign ca = smm_pkg::dim_eff(cols_a);
  assign rb = smm_pkg::dim_eff(rows_b);
  assign cb = smm_pkg::dim_eff(cols_b);

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign in_ready = !q_full;
  assign push = in_valid && in_ready;

  assign area = loading_b ? (smm_pkg::AREA_W'(rb) * smm_pkg::AREA_W'(cb))
                          : (smm_pkg::AREA_W'(ra) * smm_pkg::AREA_W'(ca));
  assign count_inc = load_count + smm_pkg::CNT_W'(1);
  assign done = smm_pkg::AREA_W'(count_inc) >= area;

  assign dims.rows_a = ra;
  assign dims.cols_a = ca;
  assign dims.cols_b = cb;

  always_comb begin
    push_cmd.addr = load_count[smm_pkg::ADDR_W-1:0];
    push_cmd.data = smm_pkg::ELEM_BITS'(element);
    if (ca != rb) begin
      push_cmd.kind = smm_pkg::CMD_ERR;
    end else if (!loading_b) begin
      push_cmd.kind = smm_pkg::CMD_STORE_A;
    end else if (done) begin
      push_cmd.kind = smm_pkg::CMD_RUN;
    end else begin
      push_cmd.kind = smm_pkg::CMD_STORE_B;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= smm_pkg::CFG_W'(1);
      cols_a <= smm_pkg::CFG_W'(1);
      rows_b <= smm_pkg::CFG_W'(1);
      cols_b <= smm_pkg::CFG_W'(1);
      load_count <= '0;
      loading_b <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        smm_pkg::REG_ROWS_A: rows_a <= cfg_data;
        smm_pkg::REG_COLS_A: cols_a <= cfg_data;
        smm_pkg::REG_ROWS_B: rows_b <= cfg_data;
        smm_pkg::REG_COLS_B: cols_b <= cfg_data;
        default: rows_a <= rows_a;
      endcase
      load_count <= '0;
      loading_b <= 1'b0;
    end else if (push && push_cmd.kind != smm_pkg::CMD_ERR) begin
      if (done) begin
        load_count <= '0;
        loading_b <= !loading_b;
      end else begin
        load_count <= count_inc;
      end
    end
  end

endmodule

/* src/smm_queue.sv */
// Short command queue between the front end and the compute back end.
module smm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output smm_pkg::cmd_t pop_cmd,
  output logic          empty
);

  smm_pkg::cmd_t                entries [smm_pkg::QUEUE_DEPTH];
  logic [smm_pkg::QP_W-1:0]     wr_ptr;
  logic [smm_pkg::QP_W-1:0]     rd_ptr;
  logic [smm_pkg::QC_W-1:0]     count;

  assign full = count == smm_pkg::QC_W'(smm_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + smm_pkg::QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + smm_pkg::QP_W'(1);
      end
      if (push && !pop) begin
        count <= count + smm_pkg::QC_W'(1);
      end else if (pop && !push) begin
        count <= count - smm_pkg::QC_W'(1);
      end
    end
  end

endmodule

/* src/smm_back.sv */
// Back end: matrix stores, multiply-accumulate pipeline and result register.
module smm_back (
  input  logic                                clk,
  input  logic                                rst,
  input  smm_pkg::dims_t                      dims,
  input  logic                                q_empty,
  input  smm_pkg::cmd_t                       q_cmd,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smm_pkg::PROD_W-1:0]   product,
  output logic                                dims_error,
  output logic                                last
);

  logic signed [smm_pkg::ELEM_BITS-1:0] mem_a [smm_pkg::STORE_DEPTH];
  logic signed [smm_pkg::ELEM_BITS-1:0] mem_b [smm_pkg::STORE_DEPTH];

  smm_pkg::back_state_t state;
  smm_pkg::back_state_t state_next;

  logic [smm_pkg::IDX_W-1:0]            i_idx;
  logic [smm_pkg::IDX_W-1:0]            j_idx;
  logic [smm_pkg::IDX_W-1:0]            k_idx;
  logic [smm_pkg::ADDR_W-1:0]           row_base;
  logic [smm_pkg::ADDR_W-1:0]           a_ptr;
  logic [smm_pkg::ADDR_W-1:0]           b_ptr;
  logic signed [smm_pkg::ELEM_BITS-1:0] a_q;
  logic signed [smm_pkg::ELEM_BITS-1:0] b_q;
  logic signed [smm_pkg::MUL_W-1:0]     prod;
  logic signed [smm_pkg::EXT_W-1:0]     prod_ext;
  logic [smm_pkg::PROD_W-1:0]           acc;
  logic                                 v1;
  logic                                 last1;
  logic                                 v2;
  logic                                 last2;
  logic                                 sum_ready;

  logic slot_free;
  logic wr_a;
  logic wr_b;
  logic start;
  logic load_err;
  logic issue;
  logic k_end;
  logic j_end;
  logic i_end;
  logic emit;
  logic final_sum;

  assign slot_free = !out_valid || out_ready;
  assign k_end = smm_pkg::DIM_W'(k_idx) == dims.cols_a - smm_pkg::DIM_W'(1);
  assign j_end = smm_pkg::DIM_W'(j_idx) == dims.cols_b - smm_pkg::DIM_W'(1);
  assign i_end = smm_pkg::DIM_W'(i_idx) == dims.rows_a - smm_pkg::DIM_W'(1);
  assign final_sum = i_end && j_end;
  assign prod_ext = smm_pkg::EXT_W'(prod);

  always_comb begin
    state_next = state;
    case (state)
      smm_pkg::ST_IDLE: begin
        if (start) begin
          state_next = smm_pkg::ST_ISSUE;
        end
      end
      smm_pkg::ST_ISSUE: begin
        if (k_end) begin
          state_next = smm_pkg::ST_WAIT;
        end
      end
      smm_pkg::ST_WAIT: begin
        if (emit) begin
          state_next = final_sum ? smm_pkg::ST_IDLE : smm_pkg::ST_ISSUE;
        end
      end
      default: state_next = smm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    emit = 1'b0;
    case (state)
      smm_pkg::ST_IDLE: begin
        q_pop = !q_empty && (q_cmd.kind != smm_pkg::CMD_ERR || slot_free);
      end
      smm_pkg::ST_ISSUE: begin
        issue = 1'b1;
      end
      smm_pkg::ST_WAIT: begin
        emit = sum_ready && slot_free;
      end
      default: q_pop = 1'b0;
    endcase
    wr_a = q_pop && q_cmd.kind == smm_pkg::CMD_STORE_A;
    wr_b = q_pop && (q_cmd.kind == smm_pkg::CMD_STORE_B || q_cmd.kind == smm_pkg::CMD_RUN);
    start = q_pop && q_cmd.kind == smm_pkg::CMD_RUN;
    load_err = q_pop && q_cmd.kind == smm_pkg::CMD_ERR;
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[q_cmd.addr] <= q_cmd.data;
    end
    a_q <= mem_a[a_ptr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[q_cmd.addr] <= q_cmd.data;
    end
    b_q <= mem_b[b_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smm_pkg::ST_IDLE;
      out_valid <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      sum_ready <= 1'b0;
    end else begin
      state <= state_next;
      v1 <= issue;
      v2 <= v1;
      if (load_err || emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        sum_ready <= 1'b0;
      end else if (v2 && last2) begin
        sum_ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    last1 <= k_end;
    last2 <= last1;
    prod <= a_q * b_q;
    if (start || emit) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod_ext[smm_pkg::PROD_W-1:0];
    end
    if (start) begin
      i_idx <= '0;
      j_idx <= '0;
      k_idx <= '0;
      row_base <= '0;
      a_ptr <= '0;
      b_ptr <= '0;
    end else if (issue) begin
      k_idx <= k_idx + smm_pkg::IDX_W'(1);
      a_ptr <= a_ptr + smm_pkg::ADDR_W'(1);
      b_ptr <= b_ptr + smm_pkg::ADDR_W'(dims.cols_b);
    end else if (emit) begin
      k_idx <= '0;
      if (j_end) begin
        j_idx <= '0;
        i_idx <= i_idx + smm_pkg::IDX_W'(1);
        row_base <= row_base + smm_pkg::ADDR_W'(dims.cols_a);
        a_ptr <= row_base + smm_pkg::ADDR_W'(dims.cols_a);
        b_ptr <= '0;
      end else begin
        j_idx <= j_idx + smm_pkg::IDX_W'(1);
        a_ptr <= row_base;
        b_ptr <= smm_pkg::ADDR_W'(j_idx) + smm_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      product <= '0;
      dims_error <= 1'b1;
      last <= 1'b1;
    end else if (emit) begin
      product <= acc;
      dims_error <= 1'b0;
      last <= final_sum;
    end
  end

`ifndef SYNTHESIS
  a_drained: assert property (@(posedge clk) disable iff (rst)
    sum_ready |-> (!v1 && !v2))
    else $error("A finished sum is flagged while products are still in flight.");

  a_fetch_from_issue: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $past(state) == smm_pkg::ST_ISSUE)
    else $error("A store read is marked valid without an issue cycle.");

  a_idle_no_sum: assert property (@(posedge clk) disable iff (rst)
    (state == smm_pkg::ST_IDLE) |-> !sum_ready)
    else $error("A finished sum is left behind in the idle state.");

  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && final_sum) |=> (state == smm_pkg::ST_IDLE && out_valid && last))
    else $error("The final result of a run did not return the back end to idle.");
`endif

endmodule

/* src/small_matrix_multiply_top.sv */
// Top level of the small matrix multiplier: front end, command queue and back end.
//
// Usage: write the four dimension registers (index 0 rows_a, 1 cols_a, 2 rows_b,
// 3 cols_b) through the cfg channel while the block is idle; each write restarts
// the load. Then send elements on the input channel, all of A in row-major order
// followed by all of B. Each element is accepted while the command queue has
// room. On the last element of B the back end computes C one element at a time,
// since it has a single multiply-accumulate unit and one read port on each store:
// each result sums cols_a products from store reads, which pass through the store
// read registers, the product register and the accumulator before the result is
// emitted. A run delivers rows_a * cols_b results, the last one with last set.
// When cols_a differs from rows_b every element gives one result with
// dims_error and last set and product zero, in the cycle after it leaves the queue.
// A stalled output holds the result register; the back end then waits, the queue
// fills and in_ready drops. Reset returns every dimension to one, clears the
// load position and empties the queue; store contents are not cleared.
module small_matrix_multiply_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [smm_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [smm_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [smm_pkg::ELEM_PORT_W-1:0]  element,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [smm_pkg::PROD_W-1:0]       product,
  output logic                                    dims_error,
  output logic                                    last
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  smm_pkg::cmd_t  push_cmd;
  smm_pkg::cmd_t  pop_cmd;
  smm_pkg::dims_t dims;

  smm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .element   (element),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .dims      (dims)
  );

  smm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  smm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .dims       (dims),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .product    (product),
    .dims_error (dims_error),
    .last       (last)
  );

endmodule
